/* rtl/dqmp_pkg.sv */
// Package with the shared types and constants of the DNS query message parser.
`timescale 1ns / 1ps
package dqmp_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_CHAR   = 3'd1,
    KIND_QDONE  = 3'd2,
    KIND_SHORT  = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_e;

  typedef enum logic [7:0] {
    PH_HEADER   = 8'b0000_0001,
    PH_LEN      = 8'b0000_0010,
    PH_LABEL    = 8'b0000_0100,
    PH_TYPE_HI  = 8'b0000_1000,
    PH_TYPE_LO  = 8'b0001_0000,
    PH_CLASS_HI = 8'b0010_0000,
    PH_CLASS_LO = 8'b0100_0000,
    PH_IGNORE   = 8'b1000_0000
  } phase_e;

  localparam int unsigned HeaderBytes = 12;
  localparam logic [7:0]  DotChar     = 8'd46;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] transaction_id;
    logic [15:0] header_flags;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [7:0]  name_char;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic    first_vld;
    result_t first;
    logic    second_vld;
    result_t second;
  } cmd_t;

endpackage

/* rtl/dqmp_if.sv */
// Valid/ready channel interfaces for packet bytes and parse results.
`timescale 1ns / 1ps
interface dqmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_end;
  modport source (output valid, packet_byte, packet_end, input ready);
  modport sink (input valid, packet_byte, packet_end, output ready);
endinterface

interface dqmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] transaction_id;
  logic [15:0] header_flags;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [7:0]  name_char;
  logic [15:0] record_type;
  logic [15:0] record_class;
  logic        run_last;
  modport source (output valid, kind, transaction_id, header_flags, question_count,
                  answer_count, authority_count, additional_count, name_char,
                  record_type, record_class, run_last, input ready);
  modport sink (input valid, kind, transaction_id, header_flags, question_count,
                answer_count, authority_count, additional_count, name_char,
                record_type, record_class, run_last, output ready);
endinterface

/* rtl/dns_query_message_parser_unit.sv */
// Top level of the DNS query message parser.
`timescale 1ns / 1ps
// Usage: packet bytes enter on in_if, one word per byte, with packet_end on the
// final byte of a message. Parse results leave on out_if, one word per result.
// Each byte yields zero, one or two results; run_last marks the last one of a
// byte. The front end parses a byte in the cycle it is accepted, so a new byte
// can be taken every cycle while the queue is not full. Its results are
// registered in a four-entry queue before they reach the output. A byte that
// makes two results sends them in turn through the back end's single output.
// When the receiver stalls, results wait in the queue and input keeps being
// accepted until the queue is full, then in_if.ready drops.
// Reset empties the queue and returns the parser to the start of a header.
// After each final byte the parser restarts with a fresh message.
module dns_query_message_parser_unit (
  input logic          clk_i,
  input logic          rst_ni,
  dqmp_in_if.sink      in_if,
  dqmp_out_if.source   out_if
);
  import dqmp_pkg::*;

  logic    cmd_valid, full, empty, pop;
  cmd_t    cmd_in, cmd_out;
  result_t res;

  dqmp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .packet_byte_i(in_if.packet_byte), .packet_end_i(in_if.packet_end),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd_in), .cmd_ready_i(!full)
  );

  dqmp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(cmd_valid), .push_data_i(cmd_in), .full_o(full), .empty_o(empty),
    .pop_i(pop), .pop_data_o(cmd_out)
  );

  dqmp_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .cmd_i(cmd_out), .pop_o(pop),
    .out_valid_o(out_if.valid), .out_o(res), .out_ready_i(out_if.ready)
  );

  assign out_if.kind             = res.kind;
  assign out_if.transaction_id   = res.transaction_id;
  assign out_if.header_flags     = res.header_flags;
  assign out_if.question_count   = res.question_count;
  assign out_if.answer_count     = res.answer_count;
  assign out_if.authority_count  = res.authority_count;
  assign out_if.additional_count = res.additional_count;
  assign out_if.name_char        = res.name_char;
  assign out_if.record_type      = res.record_type;
  assign out_if.record_class     = res.record_class;
  assign out_if.run_last         = res.run_last;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !cmd_valid) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_cmd_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (cmd_out.first_vld || cmd_out.second_vld))
    else $error("queued command without results");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> res.run_last) else $error("command retired before its last result");
endmodule

/* rtl/dqmp_front.sv */
// Front end: parses each packet byte and issues up to two results per byte.
`timescale 1ns / 1ps
module dqmp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      packet_byte_i,
  input  logic            packet_end_i,
  output logic            cmd_valid_o,
  output dqmp_pkg::cmd_t  cmd_o,
  input  logic            cmd_ready_i
);
  import dqmp_pkg::*;

  phase_e       phase_q, phase_d;
  logic [3:0]   pos_q, pos_d;
  logic [15:0]  hw_q [6];
  logic [15:0]  hw_d [6];
  logic [15:0]  qleft_q, qleft_d;
  logic [7:0]   lleft_q, lleft_d;
  logic         first_q, first_d;
  logic [15:0]  type_q, type_d;
  logic [7:0]   chi_q, chi_d;
  logic         fire;
  result_t      r0, r1, blank;
  logic         v0, v1;
  phase_e       ph_mid;

  assign in_ready_o  = cmd_ready_i;
  assign fire        = in_valid_i && cmd_ready_i;
  assign cmd_valid_o = fire && (v0 || v1);

  always_comb begin
    blank   = '0;
    r0      = blank;
    r1      = blank;
    v0      = 1'b0;
    v1      = 1'b0;
    phase_d = phase_q;
    pos_d   = pos_q;
    hw_d    = hw_q;
    qleft_d = qleft_q;
    lleft_d = lleft_q;
    first_d = first_q;
    type_d  = type_q;
    chi_d   = chi_q;
    case (phase_q)
      PH_HEADER: begin
        if (pos_q[0]) begin
          hw_d[pos_q[3:1]] = {hw_q[pos_q[3:1]][15:8], packet_byte_i};
        end else begin
          hw_d[pos_q[3:1]] = {packet_byte_i, 8'd0};
        end
        if (pos_q == 4'(HeaderBytes - 1)) begin
          v0 = 1'b1;
          r0.kind = KIND_HEADER;
          r0.transaction_id   = hw_d[0];
          r0.header_flags     = hw_d[1];
          r0.question_count   = hw_d[2];
          r0.answer_count     = hw_d[3];
          r0.authority_count  = hw_d[4];
          r0.additional_count = hw_d[5];
          qleft_d = hw_d[2];
          first_d = 1'b1;
          phase_d = (hw_d[2] != 16'd0) ? PH_LEN : PH_IGNORE;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      PH_LEN: begin
        if (packet_byte_i == 8'd0) begin
          phase_d = PH_TYPE_HI;
        end else begin
          if (!first_q) begin
            v0 = 1'b1;
            r0.kind = KIND_CHAR;
            r0.name_char = DotChar;
          end
          first_d = 1'b0;
          lleft_d = packet_byte_i;
          phase_d = PH_LABEL;
        end
      end
      PH_LABEL: begin
        v0 = 1'b1;
        r0.kind = KIND_CHAR;
        r0.name_char = packet_byte_i;
        lleft_d = lleft_q - 8'd1;
        if (lleft_q == 8'd1) phase_d = PH_LEN;
      end
      PH_TYPE_HI: begin
        type_d = {packet_byte_i, 8'd0};
        phase_d = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        type_d = {type_q[15:8], packet_byte_i};
        phase_d = PH_CLASS_HI;
      end
      PH_CLASS_HI: begin
        chi_d = packet_byte_i;
        phase_d = PH_CLASS_LO;
      end
      PH_CLASS_LO: begin
        v0 = 1'b1;
        r0.kind = KIND_QDONE;
        r0.record_type = type_q;
        r0.record_class = {chi_q, packet_byte_i};
        qleft_d = qleft_q - 16'd1;
        first_d = 1'b1;
        phase_d = (qleft_q != 16'd1) ? PH_LEN : PH_IGNORE;
      end
      default: ;
    endcase
    ph_mid = phase_d;
    if (packet_end_i) begin
      if (ph_mid == PH_HEADER) begin
        v1 = 1'b1;
        r1.kind = KIND_SHORT;
      end else if (ph_mid != PH_IGNORE) begin
        v1 = 1'b1;
        r1.kind = KIND_TRUNC;
      end
      phase_d = PH_HEADER;
      pos_d   = '0;
      for (int i = 0; i < 6; i++) hw_d[i] = '0;
      qleft_d = '0;
      lleft_d = '0;
      first_d = 1'b1;
      type_d  = '0;
      chi_d   = '0;
    end
    r1.run_last = v1;
    r0.run_last = !v1;
  end

  assign cmd_o = '{first_vld: v0, first: r0, second_vld: v1, second: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      for (int i = 0; i < 6; i++) hw_q[i] <= '0;
      qleft_q <= '0;
      lleft_q <= '0;
      first_q <= 1'b1;
      type_q  <= '0;
      chi_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hw_q    <= hw_d;
      qleft_q <= qleft_d;
      lleft_q <= lleft_d;
      first_q <= first_d;
      type_q  <= type_d;
      chi_q   <= chi_d;
    end
  end
endmodule

/* rtl/dqmp_queue.sv */
// Short queue of parse commands between the front and back ends.
`timescale 1ns / 1ps
module dqmp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dqmp_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output dqmp_pkg::cmd_t pop_data_o
);
  import dqmp_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW + 1)'(push_i) - (QueuePtrW + 1)'(pop_i);
    end
  end
endmodule

/* rtl/dqmp_back.sv */
// Back end: delivers the one or two results of each command as output words.
`timescale 1ns / 1ps
module dqmp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dqmp_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output dqmp_pkg::result_t out_o,
  input  logic           out_ready_i
);
  import dqmp_pkg::*;

  logic sel_q;
  logic has_next;
  logic take;

  assign out_valid_o = !empty_i;
  assign out_o = (sel_q || !cmd_i.first_vld) ? cmd_i.second : cmd_i.first;
  assign take = out_valid_o && out_ready_i;
  assign has_next = !sel_q && cmd_i.first_vld && cmd_i.second_vld;
  assign pop_o = take && !has_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= has_next;
    end
  end
endmodule
